// File: rtl/sm3_pkg.sv
package sm3_pkg;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       is_last;
    } sm3_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sm3_out_t;

    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    localparam logic [255:0] SM3_IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        begin
            d = {x, x} << n;
            rotl = d[63:32];
        end
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        perm0 = x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        perm1 = x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

endpackage

// File: rtl/sm3_stream_if.sv
interface sm3_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/sm3_hash_engine_top.sv
// SM3 hash engine. The input channel carries one message byte per beat with
// byte_present and is_last flags; the output channel carries the eight digest
// words, one per beat, word 0 first, with last_word set on word 7.
// A byte that does not complete a 64-byte block passes through the accept
// state and back to idle. A byte that completes a block starts a compression:
// a load state fills the round registers, 64 rounds run at one round a cycle
// on a single shared round unit, and a fold state folds the result into the
// chaining value before the engine is ready again. A last beat pads the block
// and runs one or two compressions, then presents the digest words. The
// engine takes no new byte until all eight words are taken.
// If the receiver stalls, the current word holds until it is accepted.
// Reset returns the chaining value to the SM3 initial value, clears the
// byte count and leaves the engine idle and ready.
module sm3_hash_engine_top
    import sm3_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sm3_stream_if.sink   in_ch,
    sm3_stream_if.source out_ch
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_LEN  = 3'd2;
    localparam logic [2:0] ST_RND  = 3'd3;
    localparam logic [2:0] ST_FOLD = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_ACC  = 3'd6;
    localparam logic [2:0] ST_LOAD = 3'd7;

    logic [2:0]   state_reg;
    logic         fin_reg;
    logic         second_reg;
    logic [60:0]  cnt_reg;
    logic [5:0]   pos_reg;
    logic [6:0]   rnd_reg;
    logic [2:0]   widx_reg;
    logic [31:0]  buf_reg [16];
    logic [31:0]  win_reg [16];
    logic [31:0]  v_reg [8];
    logic [31:0]  wk_reg [8];
    sm3_in_t      in_reg;

    sm3_in_t in_d;
    assign in_d = sm3_in_t'(in_ch.data);

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = (state_reg == ST_OUT);
    assign out_ch.data  = {v_reg[widx_reg], widx_reg, widx_reg == 3'd7};

    logic [3:0]  r4;
    logic [31:0] a, b, c, d, e, f, g, h, w, w4, tc, ff, gg, a12, ss1, ss2, tt1, tt2, wn;
    always_comb
    begin
        r4 = rnd_reg[3:0];
        a = wk_reg[0]; b = wk_reg[1]; c = wk_reg[2]; d = wk_reg[3];
        e = wk_reg[4]; f = wk_reg[5]; g = wk_reg[6]; h = wk_reg[7];
        w  = win_reg[r4];
        w4 = win_reg[r4 + 4'd4];
        tc = (rnd_reg < 7'd16) ? T_LOW : T_HIGH;
        if (rnd_reg < 7'd16)
        begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
        end
        else
        begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
        end
        a12 = rotl(a, 5'd12);
        ss1 = rotl(a12 + e + rotl(tc, rnd_reg[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        tt1 = ff + d + ss2 + (w ^ w4);
        tt2 = gg + h + ss1 + w;
        wn = perm1(win_reg[r4] ^ win_reg[r4 + 4'd7] ^ rotl(win_reg[r4 + 4'd13], 5'd15))
             ^ rotl(win_reg[r4 + 4'd3], 5'd7) ^ win_reg[r4 + 4'd10];
    end

    // Byte insertion into the block buffer, shared by message bytes and the pad byte.
    logic [31:0] merged;
    logic [7:0]  put_val;
    always_comb
    begin
        put_val = (state_reg == ST_ACC) ? in_reg.msg_byte : PAD_BYTE;
        merged = buf_reg[pos_reg[5:2]];
        case (pos_reg[1:0])
            2'd0: merged = {put_val, 24'd0};
            2'd1: merged[23:16] = put_val;
            2'd2: merged[15:8] = put_val;
            default: merged[7:0] = put_val;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_ch.valid)
            in_reg <= in_d;
        if (state_reg == ST_ACC && in_reg.byte_present)
            buf_reg[pos_reg[5:2]] <= merged;
        if (state_reg == ST_PAD)
        begin
            if (!second_reg)
                buf_reg[pos_reg[5:2]] <= merged;
            for (int i = 0; i < 16; i++)
                if (second_reg || 4'(i) > pos_reg[5:2])
                    buf_reg[i] <= 32'd0;
        end
        if (state_reg == ST_LEN)
        begin
            buf_reg[14] <= {cnt_reg[60:29]};
            buf_reg[15] <= {cnt_reg[28:0], 3'b000};
        end
        if (state_reg == ST_RND)
        begin
            win_reg[r4] <= wn;
            wk_reg[3] <= c;
            wk_reg[2] <= rotl(b, 5'd9);
            wk_reg[1] <= a;
            wk_reg[0] <= tt1;
            wk_reg[7] <= g;
            wk_reg[6] <= rotl(f, 5'd19);
            wk_reg[5] <= e;
            wk_reg[4] <= perm0(tt2);
        end
        else
        begin
            for (int i = 0; i < 16; i++)
                win_reg[i] <= buf_reg[i];
            for (int i = 0; i < 8; i++)
                wk_reg[i] <= v_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            fin_reg    <= 1'b0;
            second_reg <= 1'b0;
            cnt_reg    <= '0;
            pos_reg    <= '0;
            rnd_reg    <= '0;
            widx_reg   <= '0;
            for (int i = 0; i < 8; i++)
                v_reg[i] <= SM3_IV[255 - 32*i -: 32];
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    pos_reg <= cnt_reg[5:0];
                    if (in_ch.valid)
                        state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    fin_reg <= 1'b0;
                    second_reg <= 1'b0;
                    if (in_reg.byte_present)
                    begin
                        cnt_reg <= cnt_reg + 61'd1;
                        pos_reg <= pos_reg + 6'd1;
                    end
                    rnd_reg <= '0;
                    if (in_reg.byte_present && pos_reg == 6'd63)
                        state_reg <= ST_LOAD;
                    else if (in_reg.is_last)
                        state_reg <= ST_PAD;
                    else
                        state_reg <= ST_IDLE;
                end
                ST_PAD:
                begin
                    rnd_reg <= '0;
                    if (!second_reg && pos_reg >= 6'd56)
                    begin
                        second_reg <= 1'b1;
                        state_reg <= ST_LOAD;
                    end
                    else
                        state_reg <= ST_LEN;
                end
                ST_LEN:
                begin
                    second_reg <= 1'b0;
                    fin_reg <= 1'b1;
                    rnd_reg <= '0;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD:
                begin
                    state_reg <= ST_RND;
                end
                ST_RND:
                begin
                    rnd_reg <= rnd_reg + 7'd1;
                    if (rnd_reg == 7'd63)
                        state_reg <= ST_FOLD;
                end
                ST_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        v_reg[i] <= v_reg[i] ^ wk_reg[i];
                    widx_reg <= '0;
                    if (second_reg)
                        state_reg <= ST_PAD;
                    else if (fin_reg)
                        state_reg <= ST_OUT;
                    else if (in_reg.is_last)
                        state_reg <= ST_PAD;
                    else
                        state_reg <= ST_IDLE;
                end
                ST_OUT:
                begin
                    if (out_ch.ready)
                    begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                                v_reg[i] <= SM3_IV[255 - 32*i -: 32];
                            cnt_reg <= '0;
                            fin_reg <= 1'b0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/sm3_checker.sv
module sm3_checker
    import sm3_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic in_valid,
    input logic out_valid,
    input logic out_ready,
    input logic [35:0] out_data
);

    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid)) else $error("ready during output");

    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("ready right after a beat");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output not held");

    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data[0] |=> out_valid)
        else $error("digest words broken");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data[0] |=> in_ready)
        else $error("no rearm after digest");

endmodule

bind sm3_hash_engine_top sm3_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ready(in_ch.ready), .in_valid(in_ch.valid),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
